// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, muted while reset is held
`define DSRF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("dsrf check failed");

// concurrent check that also runs during reset
`define DSRF_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("dsrf reset check failed");

`endif

// File: sv/dsrf_pkg.sv
// shared types and constants of the decoded symbol repeat filter
package dsrf_pkg;

    localparam int POOL_ENTRIES = 3;
    localparam int PHYS_SLOTS   = POOL_ENTRIES + 1;
    localparam int MAX_LENGTH   = 256;

    localparam int SLOT_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int PHYS_W = $clog2(PHYS_SLOTS);
    localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int POS_W  = $clog2(MAX_LENGTH + 1);

    localparam int KIND_W = 4;
    localparam int BYTE_W = 8;
    localparam int HOLD_W = 8;

    localparam logic [HOLD_W-1:0] HOLD_RESET    = 8'd10;
    localparam logic [1:0]        RECENT_RELOAD = 2'd2;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_WAIT  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_eng_state;

    typedef struct packed {
        t_op               op;
        logic [KIND_W-1:0] symbol_kind;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
        logic              wait_value;
    } t_cmd;

    typedef struct packed {
        logic              is_new;
        logic [HOLD_W-1:0] report_state;
        logic [HOLD_W-1:0] lock_count;
    } t_result;

endpackage

// File: sv/dsrf_cmd_queue.sv
// front part: accepts input items, classifies the operation, two-entry queue
module dsrf_cmd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [1:0]          i_operation,
    input  logic [3:0]          i_symbol_kind,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  logic                i_wait_value,
    output logic                o_cmd_valid,
    output dsrf_pkg::t_cmd      o_cmd,
    input  logic                i_cmd_pop
);

    dsrf_pkg::t_cmd r_ent [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;
    logic           w_push_ok;
    logic           w_pop_ok;
    dsrf_pkg::t_cmd w_in;

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_ent[r_rd_ptr];
    assign w_push_ok   = i_push && !o_full;
    assign w_pop_ok    = i_cmd_pop && o_cmd_valid;

    always_comb begin
        w_in.op          = dsrf_pkg::t_op'(i_operation);
        w_in.symbol_kind = i_symbol_kind;
        w_in.data_byte   = i_data_byte;
        w_in.last_byte   = i_last_byte;
        w_in.wait_value  = i_wait_value;
    end

    always_comb begin
        case ({w_push_ok, w_pop_ok})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push_ok) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop_ok)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) r_ent[r_wr_ptr] <= w_in;
    end

endmodule

// File: sv/dsrf_result_queue.sv
// two-entry queue that holds finished result items for the receiver
module dsrf_result_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_push,
    input  dsrf_pkg::t_result i_res,
    output logic              o_res_room,
    output logic              o_empty,
    input  logic              i_pop,
    output dsrf_pkg::t_result o_res
);

    dsrf_pkg::t_result r_ent [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic [1:0]        n_count;
    logic              w_push_ok;
    logic              w_pop_ok;

    assign o_res_room = (r_count != 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign o_res      = r_ent[r_rd_ptr];
    assign w_push_ok  = i_res_push && o_res_room;
    assign w_pop_ok   = i_pop && !o_empty;

    always_comb begin
        case ({w_push_ok, w_pop_ok})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push_ok) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop_ok)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) r_ent[r_wr_ptr] <= i_res;
    end

endmodule

// File: sv/dsrf_engine.sv
// back part: symbol pool, byte compare against all slots, aging and result build
module dsrf_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_hold_time,
    input  logic              i_cmd_valid,
    input  dsrf_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_res_room,
    output logic              o_res_push,
    output dsrf_pkg::t_result o_res
);

    localparam int PE = dsrf_pkg::POOL_ENTRIES;
    localparam int PS = dsrf_pkg::PHYS_SLOTS;
    localparam int PW = dsrf_pkg::PHYS_W;
    localparam int SW = dsrf_pkg::SLOT_W;
    localparam int QW = dsrf_pkg::POS_W;
    localparam int AW = dsrf_pkg::ADDR_W;

    dsrf_pkg::t_eng_state r_state, n_state;

    logic [7:0]    r_hold_time, n_hold_time;
    logic [PW-1:0] r_slot_map [PS];
    logic [PW-1:0] n_slot_map [PS];
    logic [SW-1:0] r_next_slot, n_next_slot;
    logic [PE-1:0] r_flags, n_flags;
    logic [QW-1:0] r_pos, n_pos;
    logic [1:0]    r_recent, n_recent;
    logic [7:0]    r_lock, n_lock;
    logic          r_wait, n_wait;
    logic [PE-1:0] r_valid, n_valid;
    logic [7:0]    r_life [PE];
    logic [7:0]    n_life [PE];

    // per logical slot descriptors, written only when a symbol is stored
    logic [3:0]    r_slot_kind [PE];
    logic [QW-1:0] r_slot_len  [PE];
    logic [7:0]    r_bank_q    [PS];

    logic [PE-1:0] w_flags_upd;
    logic          w_in_range;
    logic [QW-1:0] w_len;
    logic          w_hit;
    logic [SW-1:0] w_hit_idx;
    logic          w_exec;
    logic          w_store;
    logic [AW-1:0] w_addr;

    assign w_exec     = (r_state == dsrf_pkg::ST_EXEC);
    assign w_in_range = (r_pos < QW'(dsrf_pkg::MAX_LENGTH));
    assign w_addr     = r_pos[AW-1:0];
    assign w_len      = w_in_range ? (r_pos + QW'(1)) : r_pos;
    assign w_store    = w_exec && i_cmd.last_byte && !w_hit;

    // one byte bank per physical buffer, all read at the current position
    for (genvar b = 0; b < PS; b++) begin : g_bank
        logic [7:0] r_mem [dsrf_pkg::MAX_LENGTH];
        always_ff @(posedge i_clk) begin
            if (w_exec && w_in_range && (r_slot_map[PE] == PW'(b))) begin
                r_mem[w_addr] <= i_cmd.data_byte;
            end
            r_bank_q[b] <= r_mem[w_addr];
        end
    end

    always_comb begin
        for (int i = 0; i < PE; i++) begin
            w_flags_upd[i] = r_flags[i];
            if (r_slot_kind[i] != i_cmd.symbol_kind) begin
                w_flags_upd[i] = 1'b0;
            end
            if (w_in_range && ((r_pos >= r_slot_len[i]) ||
                               (r_bank_q[r_slot_map[i]] != i_cmd.data_byte))) begin
                w_flags_upd[i] = 1'b0;
            end
        end
    end

    // lowest matching slot wins
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = PE - 1; i >= 0; i--) begin
            if (w_flags_upd[i] && r_valid[i] && (r_slot_len[i] == w_len)) begin
                w_hit     = 1'b1;
                w_hit_idx = SW'(i);
            end
        end
    end

    always_comb begin
        o_res.is_new       = !w_hit;
        o_res.lock_count   = r_hold_time;
        o_res.report_state = (w_hit && (r_recent == 2'd0)) ? r_hold_time : 8'd0;
    end

    always_comb begin
        n_state     = r_state;
        n_hold_time = i_cfg_valid ? i_cfg_hold_time : r_hold_time;
        n_slot_map  = r_slot_map;
        n_next_slot = r_next_slot;
        n_flags     = r_flags;
        n_pos       = r_pos;
        n_recent    = r_recent;
        n_lock      = r_lock;
        n_wait      = r_wait;
        n_valid     = r_valid;
        n_life      = r_life;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        case (r_state)
            dsrf_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        dsrf_pkg::OP_BYTE: begin
                            // bank data for the current position lands next cycle
                            if (i_res_room) n_state = dsrf_pkg::ST_EXEC;
                        end
                        dsrf_pkg::OP_TICK: begin
                            o_cmd_pop = 1'b1;
                            if (r_recent != 2'd0) n_recent = r_recent - 2'd1;
                            if (!r_wait) begin
                                if (r_lock != 8'd0) n_lock = r_lock - 8'd1;
                                for (int i = 0; i < PE; i++) begin
                                    if (r_life[i] <= 8'd1) n_valid[i] = 1'b0;
                                    if (r_life[i] != 8'd0) n_life[i] = r_life[i] - 8'd1;
                                end
                            end
                        end
                        dsrf_pkg::OP_WAIT: begin
                            o_cmd_pop = 1'b1;
                            n_wait    = i_cmd.wait_value;
                        end
                        dsrf_pkg::OP_CLEAR: begin
                            o_cmd_pop = 1'b1;
                            n_valid   = '0;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            dsrf_pkg::ST_EXEC: begin
                o_cmd_pop = 1'b1;
                n_state   = dsrf_pkg::ST_IDLE;
                n_flags   = w_flags_upd;
                n_pos     = w_len;
                if (i_cmd.last_byte) begin
                    o_res_push = 1'b1;
                    if (w_hit) begin
                        n_life[w_hit_idx] = r_hold_time;
                    end else begin
                        // staging buffer becomes the victim slot and vice versa
                        n_slot_map[r_next_slot] = r_slot_map[PE];
                        n_slot_map[PE]          = r_slot_map[r_next_slot];
                        n_valid[r_next_slot]    = 1'b1;
                        n_life[r_next_slot]     = r_hold_time;
                        n_next_slot = (r_next_slot == SW'(PE - 1)) ? '0 : r_next_slot + SW'(1);
                        n_recent    = dsrf_pkg::RECENT_RELOAD;
                    end
                    n_lock  = r_hold_time;
                    n_pos   = '0;
                    n_flags = '1;
                end
            end
            default: begin
                n_state = dsrf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsrf_pkg::ST_IDLE;
            r_hold_time <= dsrf_pkg::HOLD_RESET;
            for (int p = 0; p < PS; p++) r_slot_map[p] <= PW'(p);
            r_next_slot <= '0;
            r_flags     <= '1;
            r_pos       <= '0;
            r_recent    <= 2'd0;
            r_lock      <= 8'd0;
            r_wait      <= 1'b0;
            r_valid     <= '0;
            for (int i = 0; i < PE; i++) r_life[i] <= 8'd0;
        end else begin
            r_state     <= n_state;
            r_hold_time <= n_hold_time;
            r_slot_map  <= n_slot_map;
            r_next_slot <= n_next_slot;
            r_flags     <= n_flags;
            r_pos       <= n_pos;
            r_recent    <= n_recent;
            r_lock      <= n_lock;
            r_wait      <= n_wait;
            r_valid     <= n_valid;
            r_life      <= n_life;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_slot_kind[r_next_slot] <= i_cmd.symbol_kind;
            r_slot_len[r_next_slot]  <= w_len;
        end
    end

endmodule

// File: sv/decoded_symbol_repeat_filter_unit.sv
// top level of the decoded symbol repeat filter
// usage:
//   input side is a queue: drive push with the item fields, an item is taken
//   when push is high and full is low. operations are symbol byte, tick, set
//   wait flag and clear pool.
//   result side is a queue: while empty is low the oldest result sits on
//   o_is_new, o_report_state and o_lock_count; pop takes it. only the final
//   byte of a symbol produces a result.
//   the hold time register is written over i_cfg_valid / o_cfg_ready, ready is
//   always high; write it only while the block is idle.
// engine:
//   a symbol byte moves the engine from idle to exec (the byte banks have a
//   registered read at the current position); tick, wait and clear are done in idle.
//   an item passes through the two-entry input queue to the engine, and the
//   result of a final byte is pushed into the output queue from exec; the engine
//   leaves idle for a byte only while the result queue has room.
// reset clears the pool, counters and queues; hold time returns to 10.
// a stalled receiver fills the two-entry result queue; the engine then holds
// symbol bytes and the input queue fills and raises full.
module decoded_symbol_repeat_filter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_operation,
    input  logic [3:0] i_symbol_kind,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_wait_value,
    output logic       empty,
    input  logic       pop,
    output logic       o_is_new,
    output logic [7:0] o_report_state,
    output logic [7:0] o_lock_count,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_hold_time
);

    logic              w_cmd_valid;
    dsrf_pkg::t_cmd    w_cmd;
    logic              w_cmd_pop;
    logic              w_res_room;
    logic              w_res_push;
    dsrf_pkg::t_result w_res_in;
    dsrf_pkg::t_result w_res_out;

    assign o_cfg_ready    = 1'b1;
    assign o_is_new       = w_res_out.is_new;
    assign o_report_state = w_res_out.report_state;
    assign o_lock_count   = w_res_out.lock_count;

    dsrf_cmd_queue u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_operation   (i_operation),
        .i_symbol_kind (i_symbol_kind),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_wait_value  (i_wait_value),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    dsrf_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_hold_time (i_cfg_hold_time),
        .i_cmd_valid     (w_cmd_valid),
        .i_cmd           (w_cmd),
        .o_cmd_pop       (w_cmd_pop),
        .i_res_room      (w_res_room),
        .o_res_push      (w_res_push),
        .o_res           (w_res_in)
    );

    dsrf_result_queue u_results (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_push (w_res_push),
        .i_res      (w_res_in),
        .o_res_room (w_res_room),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_res      (w_res_out)
    );

endmodule

// File: sv/dsrf_checker.sv
// port-level checks for the repeat filter and their binding to the top level
`include "assert_macros.svh"

module dsrf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       o_is_new,
    input logic [7:0] o_report_state,
    input logic [7:0] o_lock_count
);

    // reset leaves both queues drained
    `DSRF_ASSERT_RST(a_reset_drains, i_clk, !i_rst_n |=> (empty && !full))

    // report state is either masked to zero or mirrors the lock counter
    `DSRF_ASSERT(a_report_form, i_clk, i_rst_n, !empty |-> ((o_report_state == 8'd0) || (o_report_state == o_lock_count)))

    // a new symbol always restarts the recent-output counter, masking the report
    `DSRF_ASSERT(a_new_masks, i_clk, i_rst_n, (!empty && o_is_new) |-> (o_report_state == 8'd0))

    `DSRF_ASSERT(a_res_stays, i_clk, i_rst_n, (!empty && !pop) |=> !empty)

    `DSRF_ASSERT(a_res_holds, i_clk, i_rst_n, (!empty && !pop) |=> ($stable(o_is_new) && $stable(o_report_state) && $stable(o_lock_count)))

endmodule

bind decoded_symbol_repeat_filter_unit dsrf_checker u_dsrf_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the decoded symbol repeat filter unit
module tb;

    localparam int TEXT_MAX      = 300;
    localparam int LIB_N         = 6;
    localparam int LIB_TEXT      = 24;
    localparam int SETTLE_CYCLES = 12;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       push            = 1'b0;
    logic       full;
    logic [1:0] i_operation     = dsrf_pkg::OP_BYTE;
    logic [3:0] i_symbol_kind   = 4'd0;
    logic [7:0] i_data_byte     = 8'd0;
    logic       i_last_byte     = 1'b0;
    logic       i_wait_value    = 1'b0;
    logic       empty;
    logic       pop             = 1'b0;
    logic       o_is_new;
    logic [7:0] o_report_state;
    logic [7:0] o_lock_count;
    logic       i_cfg_valid     = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_hold_time = dsrf_pkg::HOLD_RESET;

    decoded_symbol_repeat_filter_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_operation    (i_operation),
        .i_symbol_kind  (i_symbol_kind),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_wait_value   (i_wait_value),
        .empty          (empty),
        .pop            (pop),
        .o_is_new       (o_is_new),
        .o_report_state (o_report_state),
        .o_lock_count   (o_lock_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_hold_time(i_cfg_hold_time)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    dsrf_pkg::t_cmd    pending_items[$];
    dsrf_pkg::t_result expected_reports[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int queued         = 0;
    int items_taken    = 0;
    int reports_checked = 0;
    int new_reports    = 0;
    int repeat_reports = 0;
    int mismatches     = 0;

    // shadow of the filter state
    logic [7:0]                        hold_reg;
    logic [7:0]                        buf_byte [dsrf_pkg::PHYS_SLOTS][dsrf_pkg::MAX_LENGTH];
    int unsigned                       buf_len  [dsrf_pkg::PHYS_SLOTS];
    logic [3:0]                        buf_kind [dsrf_pkg::PHYS_SLOTS];
    int unsigned                       slot_phys[dsrf_pkg::PHYS_SLOTS];
    logic [dsrf_pkg::POOL_ENTRIES-1:0] live;
    logic [7:0]                        life[dsrf_pkg::POOL_ENTRIES];
    logic [dsrf_pkg::POOL_ENTRIES-1:0] still_match;
    int unsigned                       victim;
    int unsigned                       byte_pos;
    logic [1:0]                        recent_cnt;
    logic [7:0]                        lock_cnt;
    logic                              pause_aging;

    // stimulus scratch and a library of symbols to repeat
    logic [7:0] sym_text[TEXT_MAX];
    logic [7:0] lib_text[LIB_N][LIB_TEXT];
    logic [3:0] lib_kind[LIB_N];
    int         lib_len [LIB_N];

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic filter_item(input dsrf_pkg::t_cmd c);
        int unsigned stage, ph, len, v, keep;
        int hit;
        dsrf_pkg::t_result r;
        case (c.op)
            dsrf_pkg::OP_BYTE: begin
                stage = slot_phys[dsrf_pkg::POOL_ENTRIES];
                if (byte_pos < dsrf_pkg::MAX_LENGTH) begin
                    buf_byte[stage][byte_pos] = c.data_byte;
                    for (int i = 0; i < dsrf_pkg::POOL_ENTRIES; i++) begin
                        ph = slot_phys[i];
                        if (buf_kind[ph] != c.symbol_kind || byte_pos >= buf_len[ph] ||
                            buf_byte[ph][byte_pos] != c.data_byte)
                            still_match[i] = 1'b0;
                    end
                    byte_pos++;
                end else begin
                    // past the length limit only the kind is compared
                    for (int i = 0; i < dsrf_pkg::POOL_ENTRIES; i++)
                        if (buf_kind[slot_phys[i]] != c.symbol_kind)
                            still_match[i] = 1'b0;
                end
                buf_kind[stage] = c.symbol_kind;
                if (c.last_byte) begin
                    len = byte_pos;
                    buf_len[stage] = len;
                    hit = -1;
                    for (int i = 0; i < dsrf_pkg::POOL_ENTRIES; i++)
                        if (hit < 0 && still_match[i] && live[i] && buf_len[slot_phys[i]] == len)
                            hit = i;
                    if (hit < 0) begin
                        // staging buffer becomes the victim slot, victim buffer is the new stage
                        v = victim % dsrf_pkg::POOL_ENTRIES;
                        keep = slot_phys[v];
                        slot_phys[v] = slot_phys[dsrf_pkg::POOL_ENTRIES];
                        slot_phys[dsrf_pkg::POOL_ENTRIES] = keep;
                        live[v] = 1'b1;
                        life[v] = hold_reg;
                        victim = (v + 1) % dsrf_pkg::POOL_ENTRIES;
                        recent_cnt = dsrf_pkg::RECENT_RELOAD;
                    end else begin
                        life[hit] = hold_reg;
                    end
                    lock_cnt = hold_reg;
                    byte_pos = 0;
                    still_match = '1;
                    r.is_new = (hit < 0);
                    r.report_state = (recent_cnt != 0) ? 8'd0 : lock_cnt;
                    r.lock_count = lock_cnt;
                    expected_reports.push_back(r);
                end
            end
            dsrf_pkg::OP_TICK: begin
                if (recent_cnt != 0) recent_cnt--;
                if (!pause_aging) begin
                    if (lock_cnt != 0) lock_cnt--;
                    for (int i = 0; i < dsrf_pkg::POOL_ENTRIES; i++) begin
                        if (life[i] <= 1) live[i] = 1'b0;
                        if (life[i] != 0) life[i]--;
                    end
                end
            end
            dsrf_pkg::OP_WAIT: begin
                pause_aging = c.wait_value;
            end
            dsrf_pkg::OP_CLEAR: begin
                live = '0;
            end
        endcase
    endtask

    always @(posedge i_clk) begin : send_side
        dsrf_pkg::t_cmd nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || !full) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_items.pop_front();
                push          <= 1'b1;
                i_operation   <= nxt.op;
                i_symbol_kind <= nxt.symbol_kind;
                i_data_byte   <= nxt.data_byte;
                i_last_byte   <= nxt.last_byte;
                i_wait_value  <= nxt.wait_value;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_side
        dsrf_pkg::t_cmd    taken;
        dsrf_pkg::t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
            hold_reg = dsrf_pkg::HOLD_RESET;
            live = '0;
            still_match = '1;
            victim = 0;
            byte_pos = 0;
            recent_cnt = 2'd0;
            lock_cnt = 8'd0;
            pause_aging = 1'b0;
            for (int p = 0; p < dsrf_pkg::PHYS_SLOTS; p++) begin
                slot_phys[p] = p;
                buf_len[p] = 0;
                buf_kind[p] = 4'd0;
                for (int a = 0; a < dsrf_pkg::MAX_LENGTH; a++) buf_byte[p][a] = 8'd0;
            end
            for (int i = 0; i < dsrf_pkg::POOL_ENTRIES; i++) life[i] = 8'd0;
            expected_reports.delete();
        end else begin
            if (pop && !empty) begin
                if (expected_reports.size() == 0) begin
                    flag_mismatch("result with nothing pending, lock_count", o_lock_count, -1);
                end else begin
                    want = expected_reports.pop_front();
                    if (o_is_new !== want.is_new)
                        flag_mismatch("is_new", o_is_new, want.is_new);
                    if (o_report_state !== want.report_state)
                        flag_mismatch("report_state", o_report_state, want.report_state);
                    if (o_lock_count !== want.lock_count)
                        flag_mismatch("lock_count", o_lock_count, want.lock_count);
                    reports_checked++;
                    if (want.is_new) new_reports++;
                    else repeat_reports++;
                end
            end
            if (i_cfg_valid && o_cfg_ready) hold_reg = i_cfg_hold_time;
            if (push && !full) begin
                taken.op          = dsrf_pkg::t_op'(i_operation);
                taken.symbol_kind = i_symbol_kind;
                taken.data_byte   = i_data_byte;
                taken.last_byte   = i_last_byte;
                taken.wait_value  = i_wait_value;
                filter_item(taken);
                items_taken++;
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_item(input dsrf_pkg::t_op op, input logic [3:0] kind,
                            input logic [7:0] data, input logic last, input logic wv);
        dsrf_pkg::t_cmd c;
        c.op          = op;
        c.symbol_kind = kind;
        c.data_byte   = data;
        c.last_byte   = last;
        c.wait_value  = wv;
        pending_items.push_back(c);
        queued++;
    endtask

    // non-byte operation with noise on the unused fields
    task automatic add_control(input dsrf_pkg::t_op op, input logic wv);
        add_item(op, 4'($urandom), 8'($urandom), 1'($urandom), wv);
    endtask

    task automatic add_symbol(input logic [3:0] kind, input int len);
        for (int i = 0; i < len; i++)
            add_item(dsrf_pkg::OP_BYTE, kind, sym_text[i], i == len - 1, 1'($urandom));
    endtask

    task automatic add_random_event();
        int r, slot, len, pick, at;
        logic [3:0] kind;
        r = $urandom_range(99);
        if (r < 42) begin
            // repeat a remembered symbol, now and then slightly altered
            slot = $urandom_range(LIB_N - 1);
            kind = lib_kind[slot];
            len  = lib_len[slot];
            for (int i = 0; i < len; i++) sym_text[i] = lib_text[slot][i];
            pick = $urandom_range(9);
            if (pick == 0) begin
                at = $urandom_range(len - 1);
                sym_text[at] = sym_text[at] ^ 8'($urandom_range(1, 255));
            end else if (pick == 1) begin
                kind = kind ^ 4'($urandom_range(1, 15));
            end else if (pick == 2 && len > 1) begin
                len--;
            end else if (pick == 3 && len < LIB_TEXT) begin
                sym_text[len] = 8'($urandom);
                len++;
            end
            add_symbol(kind, len);
        end else if (r < 58) begin
            slot = $urandom_range(LIB_N - 1);
            kind = ($urandom_range(19) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
            len  = ($urandom_range(9) == 0) ? $urandom_range(9, LIB_TEXT) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                sym_text[i] = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                lib_text[slot][i] = sym_text[i];
            end
            lib_kind[slot] = kind;
            lib_len[slot]  = len;
            add_symbol(kind, len);
        end else if (r < 80) begin
            // long tick bursts let entries and the lock counter run out
            repeat (($urandom_range(7) == 0) ? 12 : $urandom_range(1, 3))
                add_control(dsrf_pkg::OP_TICK, 1'($urandom));
        end else if (r < 87) begin
            add_control(dsrf_pkg::OP_WAIT, $urandom_range(99) < 35);
        end else if (r < 91) begin
            add_control(dsrf_pkg::OP_CLEAR, 1'($urandom));
        end else begin
            // broken sequence: mixed kinds, maybe unterminated
            repeat ($urandom_range(1, 4))
                add_item(dsrf_pkg::OP_BYTE, 4'($urandom), 8'($urandom),
                         $urandom_range(3) == 0, 1'($urandom));
        end
    endtask

    // wait until every item is in and every report is out, then let the engine drain
    task automatic settle();
        while (pending_items.size() != 0 || push || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_hold(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_cfg_hold_time <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [3:0] kind;
        for (int s = 0; s < LIB_N; s++) begin
            lib_kind[s] = 4'($urandom_range(1, 15));
            lib_len[s]  = $urandom_range(1, 8);
            for (int i = 0; i < LIB_TEXT; i++) lib_text[s][i] = 8'($urandom_range(1, 255));
        end

        // directed: extremes of the byte, hits, eviction, paused aging, clearing
        sym_text[0] = 8'hFF;
        sym_text[1] = 8'h00;
        add_symbol(4'd15, 2);
        add_symbol(4'd15, 2);
        sym_text[0] = 8'h01;
        add_symbol(4'd1, 1);
        sym_text[0] = 8'h80;
        add_symbol(4'd0, 1);
        sym_text[0] = 8'hFF;
        add_symbol(4'd15, 2);
        sym_text[2] = 8'h7F;
        add_symbol(4'd15, 3);
        add_control(dsrf_pkg::OP_WAIT, 1'b1);
        add_control(dsrf_pkg::OP_TICK, 1'b0);
        add_control(dsrf_pkg::OP_TICK, 1'b1);
        add_control(dsrf_pkg::OP_WAIT, 1'b0);
        add_control(dsrf_pkg::OP_CLEAR, 1'b1);
        sym_text[0] = 8'h01;
        add_symbol(4'd1, 1);
        add_control(dsrf_pkg::OP_TICK, 1'b0);
        add_control(dsrf_pkg::OP_TICK, 1'b0);
        // hit once the recent-output window is over: report carries the lock count
        add_symbol(4'd1, 1);
        while (queued < 150) add_random_event();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        write_hold(8'd255);
        send_idle_pct = 68;
        queued = 0;
        while (queued < 100) add_random_event();
        settle();

        write_hold(8'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 68;
        queued = 0;
        while (queued < 150) add_random_event();
        settle();

        write_hold(8'd1);
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        queued = 0;
        while (queued < 85) add_random_event();
        settle();
        while (queued < 170) add_random_event();
        settle();

        write_hold(8'($urandom_range(3, 30)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // close any open symbol, then two overlong ones sharing the first MAX_LENGTH bytes
        sym_text[0] = 8'h20;
        add_symbol(4'd1, 1);
        kind = 4'($urandom_range(1, 15));
        for (int i = 0; i < TEXT_MAX; i++) sym_text[i] = 8'($urandom);
        add_symbol(kind, dsrf_pkg::MAX_LENGTH + 1);
        for (int i = dsrf_pkg::MAX_LENGTH; i < TEXT_MAX; i++) sym_text[i] = sym_text[i] ^ 8'h5A;
        add_symbol(kind, dsrf_pkg::MAX_LENGTH + 14);
        queued = 0;
        while (queued < 80) add_random_event();
        settle();

        $display("covered %0d items under hold times 10, 255, 0, 1 and a random one,",
                 items_taken);
        $display("  incl. overlong symbols; %0d reports checked (%0d new, %0d repeats)",
                 reports_checked, new_reports, repeat_reports);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("timeout: block stopped making progress");
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: decoded_symbol_repeat_filter_unit.f
+incdir+sv
sv/dsrf_pkg.sv
sv/dsrf_cmd_queue.sv
sv/dsrf_result_queue.sv
sv/dsrf_engine.sv
sv/decoded_symbol_repeat_filter_unit.sv
sv/dsrf_checker.sv
sim/tb.sv
